// File: rtl/core/quaternion_to_euler_angles_core_assert.svh
// assertion macros for the quaternion to euler core
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define Q2E_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define Q2E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/core/q2e_pkg.sv
// shared types and constants for the quaternion to euler core
`default_nettype none
package q2e_pkg;
  localparam int unsigned AngW = 32;
  localparam int unsigned VecW = 44;
  localparam int unsigned TermW = 64;
  localparam logic [AngW-1:0] QuarterTurn = 32'h4000_0000;
  localparam int unsigned NormExp = 40;
  localparam int unsigned PitchFrac = 30;

  typedef logic [AngW-1:0] ang_t;
  typedef logic signed [VecW-1:0] vec_t;

  typedef struct packed {
    vec_t x;
    vec_t y;
    ang_t z;
  } cordic_t;

  function automatic ang_t atan_lut(input logic [4:0] idx);
    ang_t r;
    r = '0;
    case (idx)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335086;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;       5'd21: r = 32'd326;
      5'd22: r = 32'd163;       5'd23: r = 32'd81;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/q2e_isqrt.sv
// pipelined restoring square root, one result bit per stage
`default_nettype none
module q2e_isqrt #(
  parameter int unsigned Latency = 31,
  parameter int unsigned TagW = 1
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [61:0]       rad_i,
  input  wire logic [TagW-1:0]   tag_i,
  output logic [30:0]            root_o,
  output logic [TagW-1:0]        tag_o
);
  // one result bit per stage, radicand < 2^62
  logic [61:0] rem_q [Latency+1];
  logic [30:0] res_q [Latency+1];
  logic [TagW-1:0] tag_q [Latency+1];

  always_comb begin
    rem_q[0] = rad_i;
    res_q[0] = '0;
    tag_q[0] = tag_i;
  end

  for (genvar g = 0; g < Latency; g++) begin : g_stage
    logic [61:0] rem_d;
    logic [30:0] res_d;
    logic [32:0] trial;
    logic [32:0] part;
    always_comb begin
      part  = 33'(rem_q[g] >> (2 * (30 - g)));
      trial = {res_q[g], 2'b01};
      rem_d = rem_q[g];
      res_d = {res_q[g][29:0], 1'b0};
      if (part >= trial) begin
        rem_d = rem_q[g] - (62'(trial) << (2 * (30 - g)));
        res_d = {res_q[g][29:0], 1'b1};
      end
    end
    logic [61:0] rem_r;
    logic [30:0] res_r;
    logic [TagW-1:0] tag_r;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_r <= rem_d;
        res_r <= res_d;
        tag_r <= tag_q[g];
      end
    end
    always_comb begin
      rem_q[g+1] = rem_r;
      res_q[g+1] = res_r;
      tag_q[g+1] = tag_r;
    end
  end

  assign root_o = res_q[Latency];
  assign tag_o  = tag_q[Latency];
endmodule
`default_nettype wire

// File: rtl/core/q2e_cordic.sv
// normalise, quadrant fold and unrolled vectoring cordic
`default_nettype none
module q2e_cordic #(
  parameter int unsigned Steps = 16,
  parameter int unsigned InW = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic signed [InW-1:0] y_i,
  input  wire logic signed [InW-1:0] x_i,
  output logic signed [15:0]         angle_o
);
  // stage 0: normalise so the larger magnitude lands in [2^40, 2^41)
  logic [InW-1:0] ax, ay, am;
  logic [5:0] lz;
  logic zero;
  always_comb begin
    ax = x_i[InW-1] ? InW'(-x_i) : InW'(x_i);
    ay = y_i[InW-1] ? InW'(-y_i) : InW'(y_i);
    am = ax | ay;
    zero = (am == '0);
    lz = '0;
    for (int b = 0; b <= q2e_pkg::NormExp; b++) begin
      if (am[b]) lz = 6'(q2e_pkg::NormExp - b);
    end
  end
  q2e_pkg::vec_t nx_q, ny_q;
  logic zero_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q   <= q2e_pkg::VecW'(x_i <<< lz);
      ny_q   <= q2e_pkg::VecW'(y_i <<< lz);
      zero_q <= zero;
    end
  end

  // stage 1: left half plane fold
  q2e_pkg::cordic_t st_q [Steps+1];
  q2e_pkg::cordic_t f_d;
  logic zero_p [Steps+1];
  always_comb begin
    f_d.x = nx_q; f_d.y = ny_q; f_d.z = '0;
    if (nx_q < 0) begin
      if (ny_q >= 0) begin
        f_d.x = ny_q; f_d.y = -nx_q; f_d.z = q2e_pkg::QuarterTurn;
      end else begin
        f_d.x = -ny_q; f_d.y = nx_q; f_d.z = -q2e_pkg::QuarterTurn;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0]   <= f_d;
      zero_p[0] <= zero_q;
    end
  end

  for (genvar g = 0; g < Steps; g++) begin : g_it
    q2e_pkg::cordic_t n_d;
    always_comb begin
      n_d = st_q[g];
      if (st_q[g].y >= 0) begin
        n_d.x = st_q[g].x + (st_q[g].y >>> g);
        n_d.y = st_q[g].y - (st_q[g].x >>> g);
        n_d.z = st_q[g].z + q2e_pkg::atan_lut(5'(g));
      end else begin
        n_d.x = st_q[g].x - (st_q[g].y >>> g);
        n_d.y = st_q[g].y + (st_q[g].x >>> g);
        n_d.z = st_q[g].z - q2e_pkg::atan_lut(5'(g));
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g+1]   <= n_d;
        zero_p[g+1] <= zero_p[g];
      end
    end
  end

  q2e_pkg::ang_t zr;
  always_comb begin
    zr = (zero_p[Steps] ? '0 : st_q[Steps].z) + 32'h0000_8000;
    angle_o = zr[31:16];
  end
endmodule
`default_nettype wire

// File: rtl/core/quaternion_to_euler_angles_core.sv
// top level: quaternion to zyx euler angles, fully pipelined
//
//  channel | signals                                   | direction
//  in      | in_valid_i, in_stall_o, quat_{x,y,z,w}_i  | into the core
//  out     | out_valid_o, out_stall_i, *_angle_o, pitch_clamped_o | out of the core
//
// one transaction per cycle sustained while the output is not stalled; the pipeline has:
// 3 product/term stages, 31 square root stages, 2 + CORDIC_STEPS cordic stages
// and one output register
// reset clears only the valid bits, payload registers are not reset
// the whole pipeline advances together; a stall on the output with a full
// output register freezes it, so nothing is lost or repeated
`default_nettype none
module quaternion_to_euler_angles_core #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned QUAT_FRAC_BITS = 14
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  input  wire logic signed [15:0] quat_w_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      roll_angle_o,
  output logic signed [15:0]      pitch_angle_o,
  output logic signed [15:0]      yaw_angle_o,
  output logic                    pitch_clamped_o
);
  localparam int unsigned ProdFrac = 2 * QUAT_FRAC_BITS;
  localparam int unsigned SqrtLat = 31;
  localparam int unsigned CordLat = CORDIC_STEPS + 2;
  localparam int unsigned TotLat = 3 + SqrtLat + CordLat;
  localparam int unsigned TW = q2e_pkg::TermW;

  // advance whenever the output register is free or being taken
  logic adv;
  logic out_v_q;
  logic vld_q [TotLat+1];
  assign adv = !(out_v_q && out_stall_i);
  assign in_stall_o = !adv;
  assign vld_q[0] = in_valid_i;

  for (genvar g = 0; g < TotLat; g++) begin : g_vld
    logic v_r;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= vld_q[g];
      end
    end
    assign vld_q[g+1] = v_r;
  end

  // stage a: products
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      wx_q <= quat_w_i * quat_x_i; yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i; yy_q <= quat_y_i * quat_y_i;
      wy_q <= quat_w_i * quat_y_i; zx_q <= quat_z_i * quat_x_i;
      wz_q <= quat_w_i * quat_z_i; xy_q <= quat_x_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
    end
  end

  // stage b: terms, pitch clamp and rescale
  localparam logic signed [TW-1:0] One = TW'(1) <<< ProdFrac;
  logic signed [TW-1:0] t0_q, t1_q, t3_q, t4_q, s_q;
  logic cl_q;
  logic signed [TW-1:0] t2, t2c, sv;
  logic cl;
  always_comb begin
    t2 = 2 * (TW'(wy_q) - TW'(zx_q));
    t2c = t2; cl = 1'b0;
    if (t2 > One) begin t2c = One; cl = 1'b1; end
    if (t2 < -One) begin t2c = -One; cl = 1'b1; end
    if (ProdFrac >= q2e_pkg::PitchFrac) sv = t2c >>> (ProdFrac - q2e_pkg::PitchFrac);
    else sv = t2c <<< (q2e_pkg::PitchFrac - ProdFrac);
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t0_q <= 2 * (TW'(wx_q) + TW'(yz_q));
      t1_q <= One - 2 * (TW'(xx_q) + TW'(yy_q));
      t3_q <= 2 * (TW'(wz_q) + TW'(xy_q));
      t4_q <= One - 2 * (TW'(yy_q) + TW'(zz_q));
      s_q  <= sv;
      cl_q <= cl;
    end
  end

  // stage c: s squared, |s| <= 2^30 so the magnitude fits 31 bits
  logic [30:0] s_mag;
  logic [61:0] s_sq;
  assign s_mag = s_q[TW-1] ? 31'(-s_q) : 31'(s_q);
  assign s_sq  = s_mag * s_mag;
  logic signed [31:0] s2_q;
  logic [61:0] rad_q;
  logic signed [TW-1:0] t0c_q, t1c_q, t3c_q, t4c_q;
  logic clc_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q  <= 32'(s_q);
      rad_q <= (62'd1 << (2 * q2e_pkg::PitchFrac)) - s_sq;
      t0c_q <= t0_q; t1c_q <= t1_q; t3c_q <= t3_q; t4c_q <= t4_q;
      clc_q <= cl_q;
    end
  end

  // square root, side terms travel as tag
  localparam int unsigned TagW = 4 * TW + 32 + 1;
  logic [TagW-1:0] tag_o;
  logic [30:0] root;
  q2e_isqrt #(.Latency(SqrtLat), .TagW(TagW)) u_sqrt (
    .clk_i, .en_i(adv), .rad_i(rad_q),
    .tag_i({t0c_q, t1c_q, t3c_q, t4c_q, s2_q, clc_q}),
    .root_o(root), .tag_o(tag_o)
  );
  logic signed [TW-1:0] r0, r1, r3, r4;
  logic signed [31:0] rs;
  logic rcl;
  assign {r0, r1, r3, r4, rs, rcl} = tag_o;

  logic signed [15:0] roll_w, pitch_w, yaw_w;
  q2e_cordic #(.Steps(CORDIC_STEPS), .InW(TW)) u_roll (
    .clk_i, .en_i(adv), .y_i(r0), .x_i(r1), .angle_o(roll_w));
  q2e_cordic #(.Steps(CORDIC_STEPS), .InW(TW)) u_pitch (
    .clk_i, .en_i(adv), .y_i(TW'(rs)), .x_i(TW'({1'b0, root})), .angle_o(pitch_w));
  q2e_cordic #(.Steps(CORDIC_STEPS), .InW(TW)) u_yaw (
    .clk_i, .en_i(adv), .y_i(r3), .x_i(r4), .angle_o(yaw_w));

  logic cl_p [CordLat+1];
  assign cl_p[0] = rcl;
  for (genvar g = 0; g < CordLat; g++) begin : g_cl
    logic c_r;
    always_ff @(posedge clk_i) begin
      if (adv) c_r <= cl_p[g];
    end
    assign cl_p[g+1] = c_r;
  end

  // output register
  logic signed [15:0] roll_q, pitch_q, yaw_q;
  logic clo_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= vld_q[TotLat];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      roll_q  <= roll_w;
      yaw_q   <= yaw_w;
      clo_q   <= cl_p[CordLat];
      if (pitch_w > 16'sd16384) pitch_q <= 16'sd16384;
      else if (pitch_w < -16'sd16384) pitch_q <= -16'sd16384;
      else pitch_q <= pitch_w;
    end
  end

  assign out_valid_o     = out_v_q;
  assign roll_angle_o    = roll_q;
  assign pitch_angle_o   = pitch_q;
  assign yaw_angle_o     = yaw_q;
  assign pitch_clamped_o = clo_q;

`include "quaternion_to_euler_angles_core_assert.svh"
  `Q2E_ASSERT_IMP(a_stall_iff_held, clk_i, rst_ni, in_stall_o, out_v_q && out_stall_i)
  `Q2E_ASSERT_NEXT(a_hold_out, clk_i, rst_ni, out_v_q && out_stall_i, out_v_q && $stable(roll_q))
  `Q2E_ASSERT_IMP(a_pitch_range, clk_i, rst_ni, out_v_q,
    pitch_q <= 16'sd16384 && pitch_q >= -16'sd16384)
endmodule
`default_nettype wire
